/* src/tlpw_pkg.sv */
// Package for the two-level page table walker.
// Holds item, result, operation and state types, command, access, status and entry-bit codes, and sizes.
// Used by tlpw_front, tlpw_back and the top unit; depends on nothing.
`default_nettype none

package tlpw_pkg;

  localparam int MAX_PHYS_PAGES_DEF = 16;
  localparam int PAGE_BYTES         = 4096;
  localparam int WORDS_PER_PAGE     = PAGE_BYTES / 4;
  localparam int WADDR_W            = 20;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [4:0] PAGE_COUNT_RESET = 5'd16;

  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_READ      = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;

  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_EXEC  = 2'd2;

  localparam int BIT_VALID    = 0;
  localparam int BIT_PRESENT  = 1;
  localparam int BIT_READ     = 2;
  localparam int BIT_WRITE    = 3;
  localparam int BIT_EXEC     = 4;
  localparam int BIT_USER     = 5;
  localparam int BIT_ACCESSED = 6;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_ADDR    = 2'd1,
    ST_BAD_PERM    = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_WALK,
    OP_FAIL
  } op_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RDATA,
    B_DIR,
    B_LEAF
  } back_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [13:0] word_index;
    logic [31:0] write_data;
    logic [31:0] root_table;
    logic [31:0] virt_addr;
    logic [1:0]  access_kind;
    logic        user_mode;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] trans_addr;
    logic [31:0] read_data;
  } out_item_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [WADDR_W-1:0] word_addr;
    logic [31:0]        write_data;
    logic [9:0]         leaf_index;
    logic [11:0]        offset;
    logic [1:0]         access_kind;
    logic               user_mode;
  } op_t;

endpackage

`default_nettype wire

/* src/tlpw_ram.sv */
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tlpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* src/tlpw_front.sv */
// Front part: accepts items, classifies them into operations and queues them.
// Depends on tlpw_pkg.
`default_nettype none

module tlpw_front #(
  parameter int MAX_PHYS_PAGES = tlpw_pkg::MAX_PHYS_PAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire tlpw_pkg::in_item_t request,
  input  wire logic [4:0]        page_limit,
  output logic                   head_valid,
  output tlpw_pkg::op_t          head,
  input  wire logic              deq
);

  localparam int MEM_WORDS = MAX_PHYS_PAGES * tlpw_pkg::WORDS_PER_PAGE;
  localparam int DEPTH     = tlpw_pkg::QUEUE_DEPTH;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  tlpw_pkg::op_t    queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  tlpw_pkg::op_t    op_in;
  logic             widx_ok;
  logic             root_ok;
  logic             accept;

  assign accept     = push && !full;
  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  assign widx_ok = (32'(request.word_index) < 32'(MEM_WORDS));
  assign root_ok = (request.root_table[11:0] == 12'd0) &&
                   (request.root_table[31:12] < {15'd0, page_limit});

  always_comb begin
    op_in             = '0;
    op_in.write_data  = request.write_data;
    op_in.leaf_index  = request.virt_addr[21:12];
    op_in.offset      = request.virt_addr[11:0];
    op_in.access_kind = request.access_kind;
    op_in.user_mode   = request.user_mode;
    op_in.word_addr   = tlpw_pkg::WADDR_W'(request.word_index);
    unique case (request.command)
      tlpw_pkg::CMD_WRITE: begin
        op_in.kind = widx_ok ? tlpw_pkg::OP_WRITE : tlpw_pkg::OP_FAIL;
      end
      tlpw_pkg::CMD_READ: begin
        op_in.kind = widx_ok ? tlpw_pkg::OP_READ : tlpw_pkg::OP_FAIL;
      end
      tlpw_pkg::CMD_TRANSLATE: begin
        op_in.kind      = root_ok ? tlpw_pkg::OP_WALK : tlpw_pkg::OP_FAIL;
        op_in.word_addr = {request.root_table[21:12], request.virt_addr[31:22]};
      end
      default: begin
        op_in.kind = tlpw_pkg::OP_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (accept && !deq) begin
        count <= count + CNT_W'(1);
      end else if (deq && !accept) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !deq) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not advance on accepted item");
`endif

endmodule

`default_nettype wire

/* src/tlpw_back.sv */
// Back part: carries out queued operations on the table memory and holds the result.
// Depends on tlpw_pkg and tlpw_ram.
`default_nettype none

module tlpw_back #(
  parameter int MAX_PHYS_PAGES = tlpw_pkg::MAX_PHYS_PAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire tlpw_pkg::op_t head,
  output logic               deq,
  input  wire logic [4:0]    page_limit,
  output logic               empty,
  input  wire logic          pop,
  output tlpw_pkg::out_item_t result
);

  localparam int MEM_WORDS = MAX_PHYS_PAGES * tlpw_pkg::WORDS_PER_PAGE;
  localparam int AW        = $clog2(MEM_WORDS);

  tlpw_pkg::back_state_t       state;
  tlpw_pkg::back_state_t       state_next;
  tlpw_pkg::op_t               cur;
  logic [tlpw_pkg::WADDR_W-1:0] leaf_addr;
  logic [tlpw_pkg::WADDR_W-1:0] leaf_addr_next;
  logic                        res_valid;
  tlpw_pkg::out_item_t         res_next;
  logic                        res_load;
  logic                        cur_load;
  logic                        leaf_load;
  logic                        slot_free;
  logic                        ram_we;
  logic                        ram_re;
  logic [tlpw_pkg::WADDR_W-1:0] ram_addr;
  logic [31:0]                 ram_wdata;
  logic [31:0]                 ram_rdata;
  logic                        dir_ok;
  logic                        perm_ok;
  tlpw_pkg::status_t           leaf_status;

  tlpw_ram #(
    .WIDTH (32),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign empty     = !res_valid;
  assign slot_free = !res_valid || pop;

  assign dir_ok = ram_rdata[tlpw_pkg::BIT_VALID] && ram_rdata[tlpw_pkg::BIT_PRESENT] &&
                  (ram_rdata[31:12] < {15'd0, page_limit});
  assign leaf_addr_next = {ram_rdata[21:12], cur.leaf_index};

  always_comb begin
    case (cur.access_kind)
      tlpw_pkg::ACC_READ:  perm_ok = ram_rdata[tlpw_pkg::BIT_READ];
      tlpw_pkg::ACC_WRITE: perm_ok = ram_rdata[tlpw_pkg::BIT_WRITE];
      tlpw_pkg::ACC_EXEC:  perm_ok = ram_rdata[tlpw_pkg::BIT_EXEC];
      default:             perm_ok = 1'b1;
    endcase
  end

  always_comb begin
    if (!ram_rdata[tlpw_pkg::BIT_VALID]) begin
      leaf_status = tlpw_pkg::ST_BAD_ADDR;
    end else if (!ram_rdata[tlpw_pkg::BIT_PRESENT]) begin
      leaf_status = tlpw_pkg::ST_NOT_PRESENT;
    end else if (cur.user_mode && !ram_rdata[tlpw_pkg::BIT_USER]) begin
      leaf_status = tlpw_pkg::ST_BAD_PERM;
    end else if (!perm_ok) begin
      leaf_status = tlpw_pkg::ST_BAD_PERM;
    end else if (ram_rdata[31:12] >= {15'd0, page_limit}) begin
      leaf_status = tlpw_pkg::ST_BAD_ADDR;
    end else begin
      leaf_status = tlpw_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlpw_pkg::B_IDLE: begin
        if (head_valid && head.kind == tlpw_pkg::OP_READ) begin
          state_next = tlpw_pkg::B_RDATA;
        end else if (head_valid && head.kind == tlpw_pkg::OP_WALK) begin
          state_next = tlpw_pkg::B_DIR;
        end
      end
      tlpw_pkg::B_RDATA: begin
        if (slot_free) state_next = tlpw_pkg::B_IDLE;
      end
      tlpw_pkg::B_DIR: begin
        if (dir_ok) begin
          state_next = tlpw_pkg::B_LEAF;
        end else if (slot_free) begin
          state_next = tlpw_pkg::B_IDLE;
        end
      end
      tlpw_pkg::B_LEAF: begin
        if (slot_free) state_next = tlpw_pkg::B_IDLE;
      end
      default: state_next = tlpw_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    deq       = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = head.word_addr;
    ram_wdata = head.write_data;
    cur_load  = 1'b0;
    leaf_load = 1'b0;
    res_load  = 1'b0;
    res_next  = '0;
    res_next.status = tlpw_pkg::ST_BAD_ADDR;
    unique case (state)
      tlpw_pkg::B_IDLE: begin
        if (head_valid) begin
          unique case (head.kind) inside
            tlpw_pkg::OP_WRITE: begin
              if (slot_free) begin
                deq             = 1'b1;
                ram_we          = 1'b1;
                res_load        = 1'b1;
                res_next.status = tlpw_pkg::ST_OK;
              end
            end
            tlpw_pkg::OP_READ, tlpw_pkg::OP_WALK: begin
              deq      = 1'b1;
              ram_re   = 1'b1;
              cur_load = 1'b1;
            end
            default: begin
              if (slot_free) begin
                deq      = 1'b1;
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      tlpw_pkg::B_RDATA: begin
        if (slot_free) begin
          res_load           = 1'b1;
          res_next.status    = tlpw_pkg::ST_OK;
          res_next.read_data = ram_rdata;
        end
      end
      tlpw_pkg::B_DIR: begin
        ram_addr = leaf_addr_next;
        if (dir_ok) begin
          ram_re    = 1'b1;
          leaf_load = 1'b1;
        end else if (slot_free) begin
          res_load = 1'b1;
        end
      end
      tlpw_pkg::B_LEAF: begin
        ram_addr  = leaf_addr;
        ram_wdata = ram_rdata | (32'd1 << tlpw_pkg::BIT_ACCESSED);
        if (slot_free) begin
          res_load        = 1'b1;
          res_next.status = leaf_status;
          if (leaf_status == tlpw_pkg::ST_OK) begin
            ram_we              = 1'b1;
            res_next.trans_addr = {ram_rdata[31:12], cur.offset};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlpw_pkg::B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) result <= res_next;
    if (cur_load) cur <= head;
    if (leaf_load) leaf_addr <= leaf_addr_next;
  end

`ifndef SYNTHESIS
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == tlpw_pkg::B_IDLE || state == tlpw_pkg::B_LEAF))
    else $error("memory written outside a write or leaf step");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || pop))
    else $error("waiting result overwritten");
  a_accessed_set: assert property (@(posedge clk) disable iff (rst)
    (res_load && state == tlpw_pkg::B_LEAF && res_next.status == tlpw_pkg::ST_OK) |-> ram_we)
    else $error("successful walk without accessed-bit write back");
`endif

endmodule

`default_nettype wire

/* src/two_level_page_table_walker_unit.sv */
// A write ends in the back part's idle step, one per cycle while the result slot is free;
// a read issues its memory read there and ends in the read-data step; a translate reads
// the directory, then the leaf, then writes the accessed bit, all on the single table memory port.
// A waiting result does not stop the next item until that one is ready to finish.
// Reset (rst, synchronous): queue and walker state cleared, page count set to 16.
// Table memory contents are not cleared and are undefined until written.
`default_nettype none

module two_level_page_table_walker_unit #(
  parameter int MAX_PHYS_PAGES = tlpw_pkg::MAX_PHYS_PAGES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire tlpw_pkg::in_item_t  request,
  output logic                     empty,
  input  wire logic                pop,
  output tlpw_pkg::out_item_t      result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [4:0]          cfg_data
);

  logic [4:0]    page_count;
  logic [4:0]    page_limit;
  logic          head_valid;
  tlpw_pkg::op_t head;
  logic          deq;

  assign cfg_ready  = 1'b1;
  assign page_limit = (32'(page_count) > 32'(MAX_PHYS_PAGES)) ?
                      5'(MAX_PHYS_PAGES) : page_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= tlpw_pkg::PAGE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      page_count <= cfg_data;
    end
  end

  tlpw_front #(
    .MAX_PHYS_PAGES (MAX_PHYS_PAGES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .request    (request),
    .page_limit (page_limit),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq)
  );

  tlpw_back #(
    .MAX_PHYS_PAGES (MAX_PHYS_PAGES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .deq        (deq),
    .page_limit (page_limit),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire
